// ===== hdl/z3hx_pkg.sv =====
// Shared types, constants and the digit-pair table of the hex index encoder.
package z3hx_pkg;

  localparam int QUAD_W          = 4;
  localparam int COORD_W         = 24;
  localparam int DIGITS_W        = 60;
  localparam int CNT_W           = 5;
  localparam int RES_W           = 5;
  localparam int EFF_W           = 4;
  localparam int MAX_DIGIT_PAIRS = 15;
  localparam int PROD_W          = 2 * COORD_W;

  localparam logic [COORD_W-1:0] DIV3_RECIP = 24'd11184811;
  localparam int                 DIV3_SHIFT = 25;

  localparam int                  CFG_ADDR_W     = 3;
  localparam int                  CFG_DATA_W     = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_RESOLUTION = 3'd0;

  typedef struct packed {
    logic [QUAD_W-1:0] quad;
    logic [EFF_W-1:0]  eff;
    logic              odd;
    logic              ovf;
  } z3hx_ctl_t;

  function automatic logic [3:0] pair_code(input logic [1:0] di, input logic [1:0] dj);
    logic [3:0] code;
    code = 4'b0000;
    unique case ({di, dj})
      4'b0000: code = 4'b0000;
      4'b0001: code = 4'b1010;
      4'b0010: code = 4'b1001;
      4'b0100: code = 4'b0001;
      4'b0101: code = 4'b0010;
      4'b0110: code = 4'b1000;
      4'b1000: code = 4'b0110;
      4'b1001: code = 4'b0100;
      4'b1010: code = 4'b0101;
      default: code = 4'b0000;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/z3hx_ifs.sv =====
// Valid/ready channel interfaces for cell items and index result items.
interface z3hx_in_if;
  logic                         valid;
  logic                         ready;
  logic [z3hx_pkg::QUAD_W-1:0]  quad_number;
  logic [z3hx_pkg::COORD_W-1:0] coord_i;
  logic [z3hx_pkg::COORD_W-1:0] coord_j;

  modport source (output valid, quad_number, coord_i, coord_j, input ready);
  modport sink (input valid, quad_number, coord_i, coord_j, output ready);
endinterface

interface z3hx_out_if;
  logic                          valid;
  logic                          ready;
  logic [z3hx_pkg::QUAD_W-1:0]   quad_out;
  logic [z3hx_pkg::DIGITS_W-1:0] index_digits;
  logic [z3hx_pkg::CNT_W-1:0]    digit_count;
  logic                          overflow;

  modport source (output valid, quad_out, index_digits, digit_count, overflow, input ready);
  modport sink (input valid, quad_out, index_digits, digit_count, overflow, output ready);
endinterface

// ===== hdl/z3_hex_index_encoder.sv =====
// Top level of the hex index encoder: register block, digit stages and output stage.
// Pipeline: 15 digit stages, then 1 output stage; one item per cycle while out_chan is ready.
// Each digit stage divides both coordinates by 3 once.
// Stalls ripple back stage by stage, so empty stages still take items while a result waits.
// Reset clears every stage valid bit and sets the resolution register to 0.
module z3_hex_index_encoder (
  input  logic                              clk,
  input  logic                              rst_n,
  z3hx_in_if.sink                           in_chan,
  z3hx_out_if.source                        out_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [z3hx_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [z3hx_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [z3hx_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import z3hx_pkg::*;

  localparam int NSTG = MAX_DIGIT_PAIRS;

  logic [EFF_W-1:0]    eff;
  logic                odd;
  logic                stg_valid [NSTG+1];
  logic                stg_ready [NSTG+1];
  z3hx_ctl_t           stg_ctl   [NSTG+1];
  logic [COORD_W-1:0]  stg_vi    [NSTG+1];
  logic [COORD_W-1:0]  stg_vj    [NSTG+1];
  logic [DIGITS_W-1:0] stg_lw    [NSTG+1];

  z3hx_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eff     (eff),
    .odd     (odd)
  );

  assign stg_valid[0]    = in_chan.valid;
  assign in_chan.ready   = stg_ready[0];
  assign stg_ctl[0].quad = in_chan.quad_number;
  assign stg_ctl[0].eff  = eff;
  assign stg_ctl[0].odd  = odd;
  assign stg_ctl[0].ovf  = 1'b0;
  assign stg_vi[0]       = in_chan.coord_i;
  assign stg_vj[0]       = in_chan.coord_j;
  assign stg_lw[0]       = '0;

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    z3hx_digit_stage #(
      .STAGE_IDX (k)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[k]),
      .up_ready (stg_ready[k]),
      .up_ctl   (stg_ctl[k]),
      .up_vi    (stg_vi[k]),
      .up_vj    (stg_vj[k]),
      .up_lw    (stg_lw[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_ready (stg_ready[k+1]),
      .dn_ctl   (stg_ctl[k+1]),
      .dn_vi    (stg_vi[k+1]),
      .dn_vj    (stg_vj[k+1]),
      .dn_lw    (stg_lw[k+1])
    );
  end

  z3hx_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (stg_valid[NSTG]),
    .up_ready   (stg_ready[NSTG]),
    .up_ctl     (stg_ctl[NSTG]),
    .up_vi      (stg_vi[NSTG]),
    .up_vj      (stg_vj[NSTG]),
    .up_lw      (stg_lw[NSTG]),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_quad   (out_chan.quad_out),
    .out_digits (out_chan.index_digits),
    .out_count  (out_chan.digit_count),
    .out_ovf    (out_chan.overflow)
  );

endmodule

// ===== hdl/z3hx_cfg.sv =====
// APB register block holding the grid resolution and its derived digit-pair count.
module z3hx_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [z3hx_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [z3hx_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [z3hx_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [z3hx_pkg::EFF_W-1:0]        eff,
  output logic                              odd
);
  import z3hx_pkg::*;

  logic [RES_W-1:0] resolution_r;
  logic [RES_W-1:0] resolution_nxt;
  logic [RES_W:0]   half_sum;

  always_comb begin
    resolution_nxt = resolution_r;
    if (psel && penable && pwrite && (paddr == REG_RESOLUTION)) begin
      resolution_nxt = pwdata[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resolution_r <= '0;
    end else begin
      resolution_r <= resolution_nxt;
    end
  end

  assign half_sum = ({1'b0, resolution_r} + (RES_W+1)'(1)) >> 1;
  assign eff      = (half_sum > (RES_W+1)'(MAX_DIGIT_PAIRS)) ? EFF_W'(MAX_DIGIT_PAIRS)
                                                             : half_sum[EFF_W-1:0];
  assign odd      = resolution_r[0];
  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_RESOLUTION) ? CFG_DATA_W'(resolution_r) : '0;

endmodule

// ===== hdl/z3hx_digit_stage.sv =====
// One pipeline stage that peels a base-3 digit off both coordinates and maps the pair.
module z3hx_digit_stage #(
  parameter int STAGE_IDX = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  z3hx_pkg::z3hx_ctl_t             up_ctl,
  input  logic [z3hx_pkg::COORD_W-1:0]    up_vi,
  input  logic [z3hx_pkg::COORD_W-1:0]    up_vj,
  input  logic [z3hx_pkg::DIGITS_W-1:0]   up_lw,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output z3hx_pkg::z3hx_ctl_t             dn_ctl,
  output logic [z3hx_pkg::COORD_W-1:0]    dn_vi,
  output logic [z3hx_pkg::COORD_W-1:0]    dn_vj,
  output logic [z3hx_pkg::DIGITS_W-1:0]   dn_lw
);
  import z3hx_pkg::*;

  logic                valid_r;
  z3hx_ctl_t           ctl_r, ctl_nxt;
  logic [COORD_W-1:0]  vi_r, vi_nxt, vj_r, vj_nxt;
  logic [DIGITS_W-1:0] lw_r, lw_nxt;
  logic [PROD_W-1:0]   prod_i, prod_j;
  logic [COORD_W-1:0]  rem_i, rem_j;
  logic                en;
  logic                in_use;

  assign en       = !valid_r || dn_ready;
  assign up_ready = en;

  assign prod_i = PROD_W'(up_vi) * PROD_W'(DIV3_RECIP);
  assign prod_j = PROD_W'(up_vj) * PROD_W'(DIV3_RECIP);
  assign in_use = EFF_W'(STAGE_IDX) < up_ctl.eff;

  always_comb begin
    vi_nxt  = COORD_W'(prod_i[PROD_W-1:DIV3_SHIFT]);
    vj_nxt  = COORD_W'(prod_j[PROD_W-1:DIV3_SHIFT]);
    rem_i   = up_vi - (vi_nxt + (vi_nxt << 1));
    rem_j   = up_vj - (vj_nxt + (vj_nxt << 1));
    ctl_nxt = up_ctl;
    if ((up_ctl.eff == EFF_W'(STAGE_IDX)) && ((up_vi != '0) || (up_vj != '0))) begin
      ctl_nxt.ovf = 1'b1;
    end
    lw_nxt = up_lw;
    lw_nxt[4*STAGE_IDX +: 4] = pair_code(rem_i[1:0], rem_j[1:0]) & {4{in_use}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      ctl_r <= ctl_nxt;
      vi_r  <= vi_nxt;
      vj_r  <= vj_nxt;
      lw_r  <= lw_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_ctl   = ctl_r;
  assign dn_vi    = vi_r;
  assign dn_vj    = vj_r;
  assign dn_lw    = lw_r;

endmodule

// ===== hdl/z3hx_pack.sv =====
// Final stage that left-aligns the digit word, counts digits and holds the result item.
module z3hx_pack (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  z3hx_pkg::z3hx_ctl_t             up_ctl,
  input  logic [z3hx_pkg::COORD_W-1:0]    up_vi,
  input  logic [z3hx_pkg::COORD_W-1:0]    up_vj,
  input  logic [z3hx_pkg::DIGITS_W-1:0]   up_lw,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [z3hx_pkg::QUAD_W-1:0]     out_quad,
  output logic [z3hx_pkg::DIGITS_W-1:0]   out_digits,
  output logic [z3hx_pkg::CNT_W-1:0]      out_count,
  output logic                            out_ovf
);
  import z3hx_pkg::*;

  logic                valid_r;
  logic [QUAD_W-1:0]   quad_r;
  logic [DIGITS_W-1:0] digits_r, digits_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [DIGITS_W-1:0] low_word;
  logic [5:0]          shift_amt;
  logic                en;

  assign en       = !valid_r || out_ready;
  assign up_ready = en;

  always_comb begin
    low_word = up_lw;
    if (up_ctl.odd) begin
      low_word[1:0] = 2'b00;
    end
    shift_amt  = 6'(DIGITS_W) - {up_ctl.eff, 2'b00};
    digits_nxt = low_word << shift_amt;
    count_nxt  = {up_ctl.eff, 1'b0};
    if (up_ctl.odd && (up_ctl.eff != '0)) begin
      count_nxt = count_nxt - CNT_W'(1);
    end
    ovf_nxt = up_ctl.ovf;
    if ((up_ctl.eff == EFF_W'(MAX_DIGIT_PAIRS)) && ((up_vi != '0) || (up_vj != '0))) begin
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      quad_r   <= up_ctl.quad;
      digits_r <= digits_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_quad   = quad_r;
  assign out_digits = digits_r;
  assign out_count  = count_r;
  assign out_ovf    = ovf_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_count == '0) |-> (out_digits == '0))
    else $error("digits present with zero digit count");
  a_tail_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_digits << {out_count, 1'b0}) == '0))
    else $error("bits set below the last valid digit");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CNT_W'(2 * MAX_DIGIT_PAIRS)))
    else $error("digit count beyond the word");

endmodule
